// ===== hw/rtl/bdhr_pkg.sv =====
// Package for the button debounce / hold / repeat block.
// Holds the mode and event codes, register indexes and the configuration struct.
// No dependencies.
package bdhr_pkg;

  localparam int CFG_INDEX_BITS = 8;

  // Mode codes.
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_DEBOUNCE = 3'd1;
  localparam logic [2:0] MODE_PRESSED  = 3'd2;
  localparam logic [2:0] MODE_HOLD     = 3'd3;
  localparam logic [2:0] MODE_REPEAT   = 3'd4;
  localparam logic [2:0] MODE_RELEASE  = 3'd5;

  // Event codes.
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PRESS   = 3'd1;
  localparam logic [2:0] EV_HOLD    = 3'd2;
  localparam logic [2:0] EV_REPEAT  = 3'd3;
  localparam logic [2:0] EV_RELEASE = 3'd4;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESSED_LEVEL  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TICKS     = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_TICKS   = 8'd3;

  // Register reset values.
  localparam logic [31:0] DEBOUNCE_RESET = 32'd20;
  localparam logic [31:0] HOLD_RESET     = 32'd1000;
  localparam logic [31:0] REPEAT_RESET   = 32'd200;

  typedef struct packed {
    logic        pressed_level;
    logic [31:0] debounce_ticks;
    logic [31:0] hold_ticks;
    logic [31:0] repeat_ticks;
  } cfg_t;

endpackage

// ===== hw/rtl/bdhr_cfg.sv =====
// Configuration register file of the button debounce / hold / repeat block.
// Depends on bdhr_pkg for register indexes, reset values and cfg_t.
module bdhr_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdhr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [31:0]                          cfg_data,
  output bdhr_pkg::cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressed_level  <= 1'b0;
      cfg.debounce_ticks <= bdhr_pkg::DEBOUNCE_RESET;
      cfg.hold_ticks     <= bdhr_pkg::HOLD_RESET;
      cfg.repeat_ticks   <= bdhr_pkg::REPEAT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bdhr_pkg::REG_PRESSED_LEVEL:  cfg.pressed_level  <= cfg_data[0];
        bdhr_pkg::REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_data;
        bdhr_pkg::REG_HOLD_TICKS:     cfg.hold_ticks     <= cfg_data;
        bdhr_pkg::REG_REPEAT_TICKS:   cfg.repeat_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bdhr_step.sv =====
// Next-state and event logic of the button debounce / hold / repeat block.
// Purely combinational; depends on bdhr_pkg for mode and event codes and cfg_t.
module bdhr_step #(
  parameter int TICK_BITS = 32
) (
  input  logic [2:0]           mode,
  input  logic [TICK_BITS-1:0] last_tick,
  input  logic                 pin_level,
  input  logic [31:0]          tick_now,
  input  bdhr_pkg::cfg_t       cfg,
  output logic [2:0]           mode_next,
  output logic [2:0]           event_code,
  output logic                 tick_load,
  output logic [TICK_BITS-1:0] now
);

  // Common width for comparing elapsed time against the 32-bit limits.
  localparam int CW = (TICK_BITS > 32) ? TICK_BITS : 32;

  logic [CW-1:0]        tick_ext;
  logic [TICK_BITS-1:0] elapsed;
  logic [CW-1:0]        elapsed_ext;
  logic                 down;
  logic                 past_debounce;
  logic                 past_hold;
  logic                 past_repeat;

  assign tick_ext      = CW'(tick_now);
  assign now           = tick_ext[TICK_BITS-1:0];
  assign elapsed       = now - last_tick;
  assign elapsed_ext   = CW'(elapsed);
  assign down          = (pin_level == cfg.pressed_level);
  assign past_debounce = elapsed_ext > CW'(cfg.debounce_ticks);
  assign past_hold     = elapsed_ext > CW'(cfg.hold_ticks);
  assign past_repeat   = elapsed_ext > CW'(cfg.repeat_ticks);

  always_comb begin
    mode_next  = mode;
    event_code = bdhr_pkg::EV_NONE;
    tick_load  = 1'b0;
    case (mode)
      bdhr_pkg::MODE_IDLE: begin
        if (down) begin
          tick_load = 1'b1;
          mode_next = bdhr_pkg::MODE_DEBOUNCE;
        end
      end
      bdhr_pkg::MODE_DEBOUNCE: begin
        // A failed debounce still reports a release on the following poll.
        if (past_debounce) begin
          if (down) begin
            mode_next  = bdhr_pkg::MODE_PRESSED;
            event_code = bdhr_pkg::EV_PRESS;
          end else begin
            mode_next = bdhr_pkg::MODE_RELEASE;
          end
        end
      end
      bdhr_pkg::MODE_PRESSED: begin
        if (down) begin
          tick_load = 1'b1;
          mode_next = bdhr_pkg::MODE_HOLD;
        end else begin
          mode_next = bdhr_pkg::MODE_RELEASE;
        end
      end
      bdhr_pkg::MODE_HOLD: begin
        if (!down) begin
          mode_next = bdhr_pkg::MODE_RELEASE;
        end else if (past_hold) begin
          event_code = bdhr_pkg::EV_HOLD;
          tick_load  = 1'b1;
          mode_next  = bdhr_pkg::MODE_REPEAT;
        end
      end
      bdhr_pkg::MODE_REPEAT: begin
        if (!down) begin
          mode_next = bdhr_pkg::MODE_RELEASE;
        end else if (past_repeat) begin
          event_code = bdhr_pkg::EV_REPEAT;
          tick_load  = 1'b1;
        end
      end
      bdhr_pkg::MODE_RELEASE: begin
        event_code = bdhr_pkg::EV_RELEASE;
        mode_next  = bdhr_pkg::MODE_IDLE;
      end
      default: begin
        mode_next = bdhr_pkg::MODE_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/button_debounce_hold_repeat_unit.sv =====
// Top level of the button debounce / hold / repeat block.
// Instantiates bdhr_cfg and bdhr_step; depends on bdhr_pkg.
//
// Usage: each request on the input channel (in_valid / in_ready) is one poll
// of the button, carrying the sampled pin_level and the free-running
// tick_now. For every poll the block returns exactly one result request on
// the output channel (out_valid / out_ready) with the event_code (none,
// press, hold, repeat, release) and the mode_code after that poll.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
// writes the pressed level and the debounce, hold and repeat times; it is
// always ready, and indexes past the register list are ignored. Write it
// only while no poll is in flight.
// Pipeline: a poll is captured in the input register, its step is computed
// combinationally from that register and the result lands in the output
// register. Throughput is one poll per cycle while out_ready is high: the
// mode and last-tick registers update in the same cycle that loads the
// result, so the following poll sees the new state with no bubble.
// Stalls: while out_ready is low the result holds in the output register
// and the input register keeps one more poll; in_ready drops only when both
// are full.
// Reset (rst, synchronous): mode returns to idle, the last tick to zero,
// the registers to their defaults and both pipeline registers empty.
module button_debounce_hold_repeat_unit #(
  parameter int TICK_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                pin_level,
  input  logic [31:0]                         tick_now,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          event_code,
  output logic [2:0]                          mode_code,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bdhr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]                         cfg_data
);

  bdhr_pkg::cfg_t       cfg;

  // Input register.
  logic                 in_full;
  logic                 in_pin;
  logic [31:0]          in_tick;

  // Block state.
  logic [2:0]           mode;
  logic [TICK_BITS-1:0] last_tick;

  // Step results.
  logic [2:0]           mode_next;
  logic [2:0]           step_event;
  logic                 tick_load;
  logic [TICK_BITS-1:0] now;

  logic                 advance;

  bdhr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdhr_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .mode       (mode),
    .last_tick  (last_tick),
    .pin_level  (in_pin),
    .tick_now   (in_tick),
    .cfg        (cfg),
    .mode_next  (mode_next),
    .event_code (step_event),
    .tick_load  (tick_load),
    .now        (now)
  );

  // The held poll moves on whenever the output register is empty or is
  // being emptied this cycle.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_pin  <= pin_level;
      in_tick <= tick_now;
    end
  end

  // State commits together with the result so that back-to-back polls chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= bdhr_pkg::MODE_IDLE;
      last_tick <= '0;
    end else if (advance) begin
      mode <= mode_next;
      if (tick_load) begin
        last_tick <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_code <= step_event;
      mode_code  <= mode_next;
    end
  end

endmodule

// ===== bench/bdhr_poll_checker.sv =====
`timescale 1ns / 100ps
// Checker for the button debounce / hold / repeat block: watches the poll,
// result and register channels, predicts each result and compares it.
// Depends on bdhr_pkg.
module bdhr_poll_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                pin_level,
  input  logic [31:0]                         tick_now,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [2:0]                          event_code,
  input  logic [2:0]                          mode_code,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [bdhr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]                         cfg_data,
  output int                                  failures,
  output int                                  results_seen
);

  typedef struct packed {
    logic [2:0] event_code;
    logic [2:0] mode_code;
  } poll_result_t;

  bdhr_pkg::cfg_t button_cfg;
  logic [2:0]     button_mode;
  logic [31:0]    anchor_tick;
  poll_result_t   awaited_results[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    failures++;
  endtask

  // Advances the predicted button state by one poll and returns its result.
  function automatic poll_result_t next_button_result(input logic pin,
                                                      input logic [31:0] now);
    logic         down;
    logic [31:0]  elapsed;
    poll_result_t res;
    down = (pin == button_cfg.pressed_level);
    elapsed = now - anchor_tick;
    res.event_code = bdhr_pkg::EV_NONE;
    case (button_mode)
      bdhr_pkg::MODE_IDLE: begin
        if (down) begin
          anchor_tick = now;
          button_mode = bdhr_pkg::MODE_DEBOUNCE;
        end
      end
      bdhr_pkg::MODE_DEBOUNCE: begin
        if (elapsed > button_cfg.debounce_ticks) begin
          if (down) begin
            button_mode = bdhr_pkg::MODE_PRESSED;
            res.event_code = bdhr_pkg::EV_PRESS;
          end else begin
            button_mode = bdhr_pkg::MODE_RELEASE;
          end
        end
      end
      bdhr_pkg::MODE_PRESSED: begin
        if (down) begin
          anchor_tick = now;
          button_mode = bdhr_pkg::MODE_HOLD;
        end else begin
          button_mode = bdhr_pkg::MODE_RELEASE;
        end
      end
      bdhr_pkg::MODE_HOLD: begin
        if (!down) begin
          button_mode = bdhr_pkg::MODE_RELEASE;
        end else if (elapsed > button_cfg.hold_ticks) begin
          res.event_code = bdhr_pkg::EV_HOLD;
          anchor_tick = now;
          button_mode = bdhr_pkg::MODE_REPEAT;
        end
      end
      bdhr_pkg::MODE_REPEAT: begin
        if (!down) begin
          button_mode = bdhr_pkg::MODE_RELEASE;
        end else if (elapsed > button_cfg.repeat_ticks) begin
          res.event_code = bdhr_pkg::EV_REPEAT;
          anchor_tick = now;
        end
      end
      bdhr_pkg::MODE_RELEASE: begin
        res.event_code = bdhr_pkg::EV_RELEASE;
        button_mode = bdhr_pkg::MODE_IDLE;
      end
      default: begin
        button_mode = bdhr_pkg::MODE_IDLE;
      end
    endcase
    res.mode_code = button_mode;
    return res;
  endfunction

  always @(posedge clk) begin : watch_channels
    poll_result_t want;
    if (rst) begin
      button_cfg.pressed_level = 1'b0;
      button_cfg.debounce_ticks = bdhr_pkg::DEBOUNCE_RESET;
      button_cfg.hold_ticks = bdhr_pkg::HOLD_RESET;
      button_cfg.repeat_ticks = bdhr_pkg::REPEAT_RESET;
      button_mode = bdhr_pkg::MODE_IDLE;
      anchor_tick = '0;
      awaited_results.delete();
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bdhr_pkg::REG_PRESSED_LEVEL:  button_cfg.pressed_level = cfg_data[0];
          bdhr_pkg::REG_DEBOUNCE_TICKS: button_cfg.debounce_ticks = cfg_data;
          bdhr_pkg::REG_HOLD_TICKS:     button_cfg.hold_ticks = cfg_data;
          bdhr_pkg::REG_REPEAT_TICKS:   button_cfg.repeat_ticks = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(next_button_result(pin_level, tick_now));
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result event %0d mode %0d with no poll waiting",
                                    event_code, mode_code));
        end else begin
          want = awaited_results.pop_front();
          if (event_code !== want.event_code) begin
            report_mismatch($sformatf("event_code %0d, expected %0d",
                                      event_code, want.event_code));
          end
          if (mode_code !== want.mode_code) begin
            report_mismatch($sformatf("mode_code %0d, expected %0d",
                                      mode_code, want.mode_code));
          end
        end
      end
    end
  end

endmodule

// ===== bench/button_debounce_hold_repeat_unit_test.sv =====
`timescale 1ns / 100ps
// Top of the bench for button_debounce_hold_repeat_unit: clock, reset, poll
// and register stimulus, result back-pressure and the verdict.
// Depends on bdhr_pkg, the block's RTL and bdhr_poll_checker.
module button_debounce_hold_repeat_unit_test;

  // Generous bound on the whole run; the slowest legal run is far shorter.
  localparam int CYCLE_LIMIT = 200000;
  // Wait after the last result, in clock cycles, so that anything stray
  // is still caught.
  localparam int SETTLE_CYCLES = 8;
  // Length of the one long hold-off on the result side.
  localparam int SQUEEZE_CYCLES = 64;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                pin_level = 1'b0;
  logic [31:0]                         tick_now = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [2:0]                          event_code;
  logic [2:0]                          mode_code;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [bdhr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [31:0]                         cfg_data = '0;

  int          failures;
  int          results_seen;
  int          polls_sent = 0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  // Stimulus-side view of the configuration: which pin level means "down"
  // and how far the tick moves between polls.
  logic        active_level = 1'b0;
  logic [31:0] tick_clock = '0;
  int          tick_span = 2;

  // Raised by the stimulus to ask the result side for one long hold-off.
  bit squeeze_request = 1'b0;

  button_debounce_hold_repeat_unit dut (.*);

  bdhr_poll_checker poll_checker (.*);

  always #1 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side. It runs in stretches: some fully ready, some with light or
  // heavy random stalls, and once a long hold-off so that both pipeline
  // registers fill and in_ready drops while polls keep coming.
  initial begin : result_drain
    int run_len;
    int stall_pct;
    @(posedge clk);
    forever begin
      if (squeeze_request) begin
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_request = 1'b0;
      end else begin
        run_len = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 60;
          default: stall_pct = 85;
        endcase
        repeat (run_len) begin
          out_ready <= ($urandom_range(0, 99) >= stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  // Offers one poll request and returns at the edge that accepts it. Polls
  // go out in bursts; when a burst runs out, valid may drop for a random gap.
  // Valid is never lowered and raised in the same step.
  task automatic send_poll(input logic pin, input logic [31:0] tick);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    pin_level <= pin;
    tick_now <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    polls_sent++;
  endtask

  // Moves the tick forward by a random step and polls with the button
  // either down or up under the current pressed level.
  task automatic poll_later(input logic down);
    tick_clock += $urandom_range(0, tick_span);
    send_poll(down ? active_level : ~active_level, tick_clock);
  endtask

  // Stops offering polls and waits until every poll has its result. Each
  // poll yields exactly one result, so the block is then empty.
  task automatic settle_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (results_seen != polls_sent) @(posedge clk);
  endtask

  // Writes one register; cfg_valid stays high for a following write and is
  // dropped by the caller after the last one.
  task automatic write_register(input logic [bdhr_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Loads a full setting while the block is idle. The pressed level rides in
  // bit 0 with random upper bits, and sometimes a write to an index past the
  // register list is slipped in, which the block must ignore.
  task automatic load_settings(input logic level, input logic [31:0] debounce,
                               input logic [31:0] hold, input logic [31:0] rep,
                               input bit stray_write);
    settle_block();
    write_register(bdhr_pkg::REG_PRESSED_LEVEL, {31'($urandom()), level});
    if (stray_write) begin
      write_register(bdhr_pkg::CFG_INDEX_BITS'(
                       $urandom_range(bdhr_pkg::REG_REPEAT_TICKS + 1, 255)),
                     $urandom());
    end
    write_register(bdhr_pkg::REG_DEBOUNCE_TICKS, debounce);
    write_register(bdhr_pkg::REG_HOLD_TICKS, hold);
    write_register(bdhr_pkg::REG_REPEAT_TICKS, rep);
    cfg_valid <= 1'b0;
    active_level = level;
  endtask

  // Random polls for one setting. Most are clean presses: a few polls up, a
  // long stretch down so that debounce, hold and repeat all get reached, then
  // a release. The rest are short bouncy contacts and polls at random ticks.
  // Now and then the tick is pushed near its top so that it wraps mid-press.
  task automatic run_phase(input int polls);
    int stop_at;
    int kind;
    stop_at = polls_sent + polls;
    while (polls_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        tick_clock = 32'hFFFF_FFFF - $urandom_range(0, 40);
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        repeat ($urandom_range(0, 2)) poll_later(1'b0);
        repeat ($urandom_range(1, 30)) poll_later(1'b1);
        repeat ($urandom_range(1, 3)) poll_later(1'b0);
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 4)) poll_later(1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          tick_clock = $urandom();
          send_poll(1'($urandom_range(0, 1)), tick_clock);
        end
      end
    end
  endtask

  initial begin : stimulus
    while (rst) @(posedge clk);

    // Opening walk under the reset setting: low level is pressed, debounce
    // 20, hold 1000, repeat 200. Each wait sits exactly on and one past its
    // limit, since the comparison is strict.
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd100);
    send_poll(1'b0, 32'd120);
    send_poll(1'b0, 32'd121);
    send_poll(1'b0, 32'd122);
    send_poll(1'b0, 32'd1122);
    send_poll(1'b0, 32'd1123);
    send_poll(1'b0, 32'd1323);
    send_poll(1'b0, 32'd1324);
    send_poll(1'b1, 32'd1330);
    send_poll(1'b1, 32'd1331);
    // A press that has let go by the end of debounce still passes through
    // the release mode and reports a release.
    send_poll(1'b0, 32'd2000);
    send_poll(1'b1, 32'd2021);
    send_poll(1'b1, 32'd2022);
    // Debounce across the tick wrap, then a release straight from pressed.
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b0, 32'h0000_0005);
    send_poll(1'b1, 32'd6);
    send_poll(1'b1, 32'd7);
    // Start at the very top of the tick range and let go during hold. The
    // release poll reports a release whatever the pin says.
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd20);
    send_poll(1'b0, 32'd21);
    send_poll(1'b1, 32'd30);
    send_poll(1'b0, 32'd40);
    tick_clock = 32'd40;

    // Fixed settings first: all times zero, all times at their maximum (the
    // block then never leaves debounce), a hold that never fires, and a
    // repeat that never fires.
    load_settings(1'b1, '0, '0, '0, 1'b1);
    tick_span = 2;
    run_phase(60);
    load_settings(1'b0, '1, '1, '1, 1'b0);
    tick_span = 8;
    run_phase(20);
    load_settings(1'b1, 32'd2, '1, '0, 1'b1);
    tick_span = 2;
    run_phase(40);
    load_settings(1'b0, 32'd1, 32'd3, '1, 1'b0);
    run_phase(40);

    // Random short times so that presses reach hold and repeat often.
    for (int phase = 0; phase < 6; phase++) begin
      load_settings(1'($urandom_range(0, 1)), $urandom_range(0, 6),
                    $urandom_range(0, 20), $urandom_range(0, 8),
                    1'($urandom_range(0, 1)));
      tick_span = $urandom_range(1, 6);
      if (phase == 1) begin
        squeeze_request = 1'b1;
      end
      run_phase(75);
    end

    settle_block();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
